/* sv/dchs_pkg.sv */
// Shared types and codes for the depth/color histogram selector.
package dchs_pkg;

	// Operation codes of an input item; code 3 is unused and does nothing.
	typedef enum logic [1:0] {
		OP_INC   = 2'd0,
		OP_DEC   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	// Result status codes.
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_COLOR = 3'd1;
	localparam logic [2:0] ST_DEPTH = 3'd2;
	localparam logic [2:0] ST_ROW   = 3'd3;
	localparam logic [2:0] ST_ZERO  = 3'd4;
	localparam logic [2:0] ST_SAT   = 3'd5;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_UPD,
		S_SCAN1,
		S_EVAL,
		S_TARGET,
		S_SCAN2,
		S_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic clear;       // write zero at the clear pointer, advance it
		logic load;        // capture input fields, clear result staging
		logic scan_start;  // restart the cell scan
		logic pass2;       // the scan being started is the pick pass
		logic mult;        // form the two partial products of the target
		logic add;         // sum partial products into the target
		logic upd_commit;  // finish an increment or decrement
		logic push;        // move staged result into the output register
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic clr_last;
		op_t  op;
		logic scan_empty;
		logic scan_done;
		logic any;
		logic weighted;
	} dp_sts_t;

endpackage

/* sv/dchs_ctrl.sv */
// Controller state machine: sequences clearing, updates, scans and result handoff.
module dchs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  dchs_pkg::dp_sts_t sts,
	output dchs_pkg::dp_cmd_t cmd
);

	dchs_pkg::state_t state_q, state_next;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dchs_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			dchs_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_next = dchs_pkg::S_IDLE;
				end
			end
			dchs_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = dchs_pkg::S_DISPATCH;
				end
			end
			dchs_pkg::S_DISPATCH: begin
				unique case (sts.op)
					dchs_pkg::OP_INC, dchs_pkg::OP_DEC: begin
						state_next = dchs_pkg::S_UPD;
					end
					dchs_pkg::OP_QUERY: begin
						if (sts.scan_empty) begin
							state_next = dchs_pkg::S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_next     = dchs_pkg::S_SCAN1;
						end
					end
					default: begin
						state_next = dchs_pkg::S_DONE;
					end
				endcase
			end
			dchs_pkg::S_UPD: begin
				cmd.upd_commit = 1'b1;
				state_next     = dchs_pkg::S_DONE;
			end
			dchs_pkg::S_SCAN1: begin
				if (sts.scan_done) begin
					state_next = dchs_pkg::S_EVAL;
				end
			end
			dchs_pkg::S_EVAL: begin
				if (sts.any && sts.weighted) begin
					cmd.mult   = 1'b1;
					state_next = dchs_pkg::S_TARGET;
				end else begin
					state_next = dchs_pkg::S_DONE;
				end
			end
			dchs_pkg::S_TARGET: begin
				cmd.add        = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.pass2      = 1'b1;
				state_next     = dchs_pkg::S_SCAN2;
			end
			dchs_pkg::S_SCAN2: begin
				if (sts.scan_done) begin
					state_next = dchs_pkg::S_DONE;
				end
			end
			dchs_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.push   = 1'b1;
					state_next = dchs_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = dchs_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != dchs_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* sv/dchs_dp.sv */
// Datapath: cell memory, range checks, scan counters, accumulators and pick target.
module dchs_dp #(
	parameter int MAX_DEPTH  = 15,
	parameter int MAX_COLORS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dchs_pkg::dp_cmd_t cmd,
	output dchs_pkg::dp_sts_t sts,
	input  logic              cfg_we,
	input  logic [4:0]        cfg_color_count,
	input  logic [1:0]        operation,
	input  logic [7:0]        depth,
	input  logic [7:0]        color,
	input  logic [31:0]       min_support,
	input  logic              weighted_mode,
	input  logic [31:0]       random_draw,
	output logic [2:0]        status,
	output logic              found,
	output logic [3:0]        picked_color,
	output logic [3:0]        picked_depth,
	output logic [31:0]       picked_weight
);

	localparam int NUM_CELLS = (MAX_DEPTH + 1) * MAX_COLORS;
	localparam int AW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int CW        = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int DW        = (MAX_DEPTH > 0) ? $clog2(MAX_DEPTH + 1) : 1;
	localparam int RW        = $clog2(MAX_DEPTH + 2);
	localparam int TOT_W     = 32 + $clog2(NUM_CELLS + 1);

	// configuration and row count
	logic [4:0]    color_count_q;
	logic [RW-1:0] rows_q;
	logic [4:0]    nc;

	// captured input item
	dchs_pkg::op_t op_q;
	logic [7:0]    depth_q;
	logic [7:0]    color_q;
	logic [31:0]   thr_q;
	logic          wmode_q;
	logic [31:0]   draw_q;

	// cell memory
	logic [31:0]   cell_mem_q [NUM_CELLS];
	logic [31:0]   rdata_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic          we;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] cell_addr;

	// update checks
	logic          color_bad;
	logic          depth_bad;
	logic          row_bad;
	logic [2:0]    upd_st;
	logic          upd_ok;

	// scan
	logic          issuing_q;
	logic          pass2_q;
	logic [CW-1:0] sc_q;
	logic [DW-1:0] sd_q;
	logic [AW-1:0] sa_q;
	logic          d_last;
	logic          c_last;
	logic          v_s1;
	logic          last_s1;
	logic [CW-1:0] c_s1;
	logic [DW-1:0] d_s1;
	logic          cand;

	// accumulators and staging
	logic             any_q;
	logic             picked_q;
	logic [CW-1:0]    lc_q;
	logic [DW-1:0]    ld_q;
	logic [31:0]      lw_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] run_q;
	logic [TOT_W-1:0] run_next;
	logic [TOT_W-1:0] target_q;
	logic [63:0]      p_lo_q;
	logic [TOT_W-1:0] p_hi_q;
	logic [2:0]       st_q;

	assign nc = (int'(color_count_q) > MAX_COLORS) ? 5'(MAX_COLORS) : color_count_q;

	assign color_bad = int'(color_q) >= int'(nc);
	assign depth_bad = int'(depth_q) > MAX_DEPTH;
	assign row_bad   = (int'(depth_q) >= int'(rows_q)) || depth_bad;
	assign cell_addr = AW'(int'(depth_q) * MAX_COLORS + int'(color_q));

	always_comb begin
		if (op_q == dchs_pkg::OP_INC) begin
			priority if (color_bad) begin
				upd_st = dchs_pkg::ST_COLOR;
			end else if (depth_bad) begin
				upd_st = dchs_pkg::ST_DEPTH;
			end else if (rdata_q == 32'hFFFF_FFFF) begin
				upd_st = dchs_pkg::ST_SAT;
			end else begin
				upd_st = dchs_pkg::ST_OK;
			end
		end else begin
			priority if (row_bad) begin
				upd_st = dchs_pkg::ST_ROW;
			end else if (color_bad) begin
				upd_st = dchs_pkg::ST_COLOR;
			end else if (rdata_q == 32'd0) begin
				upd_st = dchs_pkg::ST_ZERO;
			end else begin
				upd_st = dchs_pkg::ST_OK;
			end
		end
	end

	assign upd_ok = (upd_st == dchs_pkg::ST_OK);

	// memory ports
	assign raddr = issuing_q ? sa_q : cell_addr;
	assign we    = cmd.clear || (cmd.upd_commit && upd_ok);
	assign waddr = cmd.clear ? clr_q : cell_addr;
	always_comb begin
		priority if (cmd.clear) begin
			wdata = 32'd0;
		end else if (op_q == dchs_pkg::OP_INC) begin
			wdata = rdata_q + 32'd1;
		end else begin
			wdata = rdata_q - 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			cell_mem_q[waddr] <= wdata;
		end
		rdata_q <= cell_mem_q[raddr];
	end

	// scan position
	assign d_last = int'(sd_q) == int'(rows_q) - 1;
	assign c_last = int'(sc_q) == int'(nc) - 1;
	assign cand   = (rdata_q != 32'd0) && (rdata_q >= thr_q);
	assign run_next = run_q + TOT_W'(rdata_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= 5'd16;
			rows_q        <= '0;
			clr_q         <= '0;
			issuing_q     <= 1'b0;
			v_s1          <= 1'b0;
			any_q         <= 1'b0;
			picked_q      <= 1'b0;
			st_q          <= dchs_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				color_count_q <= cfg_color_count;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.upd_commit) begin
				st_q <= upd_st;
				if (op_q == dchs_pkg::OP_INC && !color_bad && !depth_bad &&
				    int'(rows_q) < int'(depth_q) + 1) begin
					rows_q <= RW'(int'(depth_q) + 1);
				end
			end

			v_s1 <= issuing_q;
			if (cmd.scan_start) begin
				issuing_q <= 1'b1;
			end else if (issuing_q && c_last && d_last) begin
				issuing_q <= 1'b0;
			end

			if (cmd.load) begin
				any_q <= 1'b0;
				st_q  <= dchs_pkg::ST_OK;
			end else if (v_s1 && cand && !pass2_q) begin
				any_q <= 1'b1;
			end

			if (cmd.scan_start) begin
				picked_q <= 1'b0;
			end else if (v_s1 && cand && pass2_q && !picked_q && run_next > target_q) begin
				picked_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= dchs_pkg::op_t'(operation);
			depth_q <= depth;
			color_q <= color;
			thr_q   <= min_support;
			wmode_q <= weighted_mode;
			draw_q  <= random_draw;
			lc_q    <= '0;
			ld_q    <= '0;
			lw_q    <= '0;
			total_q <= '0;
		end

		if (cmd.scan_start) begin
			pass2_q <= cmd.pass2;
			sc_q    <= '0;
			sd_q    <= '0;
			sa_q    <= '0;
			run_q   <= '0;
		end else if (issuing_q) begin
			if (d_last) begin
				sd_q <= '0;
				sc_q <= sc_q + CW'(1);
				sa_q <= AW'(int'(sc_q) + 1);
			end else begin
				sd_q <= sd_q + DW'(1);
				sa_q <= AW'(int'(sa_q) + MAX_COLORS);
			end
		end

		// tags line up with the registered memory read
		last_s1 <= c_last && d_last;
		c_s1    <= sc_q;
		d_s1    <= sd_q;

		if (v_s1 && cand) begin
			if (!pass2_q) begin
				lc_q    <= c_s1;
				ld_q    <= d_s1;
				lw_q    <= rdata_q;
				total_q <= total_q + TOT_W'(rdata_q);
			end else if (!picked_q) begin
				run_q <= run_next;
				if (run_next > target_q) begin
					lc_q <= c_s1;
					ld_q <= d_s1;
					lw_q <= rdata_q;
				end
			end
		end

		// target = draw * total / 2^32, split at bit 32 of the total
		if (cmd.mult) begin
			p_lo_q <= 64'(draw_q) * 64'(total_q[31:0]);
			p_hi_q <= TOT_W'(draw_q) * TOT_W'(total_q[TOT_W-1:32]);
		end
		if (cmd.add) begin
			target_q <= p_hi_q + TOT_W'(p_lo_q[63:32]);
		end

		if (cmd.push) begin
			status        <= st_q;
			found         <= any_q;
			picked_color  <= 4'(lc_q);
			picked_depth  <= 4'(ld_q);
			picked_weight <= lw_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.clr_last   = (int'(clr_q) == NUM_CELLS - 1);
		sts.op         = op_q;
		sts.scan_empty = (nc == 5'd0) || (rows_q == '0);
		sts.scan_done  = v_s1 && last_s1;
		sts.any        = any_q;
		sts.weighted   = wmode_q;
	end

endmodule

/* sv/depth_color_histogram_selector_unit.sv */
// Top level of the depth/color histogram with a roulette-wheel candidate selector.
// Keeps one 32-bit count per (depth, color) cell, (MAX_DEPTH+1) x MAX_COLORS cells
// in a single-port-write, registered-read memory, plus the number of depth rows in
// use. Each input transfer carries one operation and yields exactly one result
// transfer. After reset the block sweeps the memory to zero, one cell a cycle, with
// in_stall high for the whole sweep; color_count writes are still taken during it.
// An increment or decrement passes from accept to the next accept through capture,
// memory read, checks plus write-back and result handoff. A query scans the active
// cells (colors outer, depths inner) through the memory read port, one cell a
// cycle; last-candidate mode scans them once, weighted mode scans them a second
// time when the first scan finds a candidate. The second scan of a weighted query
// runs against a target formed by two multiplies of the 32-bit draw by the low
// 32 bits and the upper bits of the candidate total. Results sit in an output
// register, so a finished result may wait under out_stall while the block takes
// the next input transfer; beyond the cycles an operation occupies it, the block
// also holds off while a second result is ready before the first is taken.
// color_count is written over a valid/ready port that is always ready and must be
// written only while the block is idle.
module depth_color_histogram_selector_unit #(
	parameter int MAX_DEPTH  = 15,
	parameter int MAX_COLORS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  depth,
	input  logic [7:0]  color,
	input  logic [31:0] min_support,
	input  logic        weighted_mode,
	input  logic [31:0] random_draw,

	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        found,
	output logic [3:0]  picked_color,
	output logic [3:0]  picked_depth,
	output logic [31:0] picked_weight,

	// color_count register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  color_count
);

	dchs_pkg::dp_cmd_t cmd;
	dchs_pkg::dp_sts_t sts;

	// the register takes a transfer in any cycle
	assign cfg_ready = 1'b1;

	dchs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dchs_dp #(
		.MAX_DEPTH  (MAX_DEPTH),
		.MAX_COLORS (MAX_COLORS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_color_count (color_count),
		.operation       (operation),
		.depth           (depth),
		.color           (color),
		.min_support     (min_support),
		.weighted_mode   (weighted_mode),
		.random_draw     (random_draw),
		.status          (status),
		.found           (found),
		.picked_color    (picked_color),
		.picked_depth    (picked_depth),
		.picked_weight   (picked_weight)
	);

`ifndef SYNTH
	// one item at a time: an accepted transfer closes the input side
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// a found candidate is a query result with a nonzero count
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == dchs_pkg::ST_OK && picked_weight != 32'd0)
		else $error("found result with bad status or zero weight");

	// no candidate means an empty selection
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> picked_weight == 32'd0 && picked_color == 4'd0 &&
			picked_depth == 4'd0)
		else $error("selection fields set without a candidate");
`endif

endmodule
